@@ rtl/sts_pkg.sv @@
// Package for the sparse triangular solve block: widths, defaults, shared types.
// No dependencies.
package sts_pkg;
   localparam int IndexWidth        = 12;
   localparam int DataWidth         = 32;
   localparam int AccWidth          = 64;
   localparam int DefaultMaxRows    = 4096;
   localparam int DefaultFracBits   = 16;

   typedef struct packed {
      logic [IndexWidth-1:0] row;
      logic [IndexWidth-1:0] column;
      logic signed [DataWidth-1:0] entry_value;
      logic signed [DataWidth-1:0] rhs;
      logic row_first;
      logic row_last;
   } req_type;

   typedef struct packed {
      logic [IndexWidth-1:0] solution_index;
      logic signed [DataWidth-1:0] solution_value;
      logic zero_diagonal;
      logic saturated;
   } rsp_type;

   // Divider start command.
   typedef struct packed {
      logic start;
      logic signed [AccWidth-1:0] numerator;
      logic signed [DataWidth-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic done;
      logic busy;
      logic signed [DataWidth-1:0] quotient;
      logic clip;
   } div_sts_type;
endpackage

@@ rtl/sts_if.sv @@
// Valid/ready channel interface carrying a packed payload.
// Depends on nothing; payload type is a parameter.
interface sts_if #(parameter type payload_type = logic) (input logic clock);
   logic valid;
   logic ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/sts_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sts_ram #(
   parameter int Width = 32,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/sts_div.sv @@
// Radix-2 restoring divider: 64-bit numerator by 32-bit divisor, truncating,
// saturated to 32 bits. Depends on sts_pkg.
module sts_div
   import sts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_sts_type sts
);
   localparam int CountWidth = $clog2(AccWidth + 1);

   logic [AccWidth-1:0]   quo_ff, quo_in;
   logic [DataWidth:0]    rem_ff, rem_in;
   logic [DataWidth-1:0]  den_ff, den_in;
   logic                  neg_ff, neg_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [AccWidth-1:0]  num_mag;
   logic [DataWidth-1:0] den_mag;
   logic [DataWidth:0]   shifted;
   logic [AccWidth:0]    signed_q;
   logic [AccWidth-1:0]  lim;

   always_comb begin
      num_mag = cmd.numerator[AccWidth-1] ? AccWidth'(-cmd.numerator) : cmd.numerator;
      den_mag = cmd.divisor[DataWidth-1] ? DataWidth'(-cmd.divisor) : cmd.divisor;
      shifted = {rem_ff[DataWidth-1:0], quo_ff[AccWidth-1]};
      quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (cmd.start) begin
         quo_in = num_mag; rem_in = '0; den_in = den_mag;
         neg_in = cmd.numerator[AccWidth-1] ^ cmd.divisor[DataWidth-1];
         cnt_in = CountWidth'(AccWidth); busy_in = 1'b1;
      end else if (busy_ff) begin
         // advance one quotient bit
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = shifted - {1'b0, den_ff};
            quo_in = {quo_ff[AccWidth-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[AccWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CountWidth'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in; neg_ff <= neg_in;
   end

   // magnitude limit: 2^31-1 positive, 2^31 negative
   always_comb begin
      lim = neg_ff ? (AccWidth'(1) << (DataWidth-1))
                   : ((AccWidth'(1) << (DataWidth-1)) - AccWidth'(1));
      signed_q = neg_ff ? (AccWidth+1)'(-{1'b0, quo_ff}) : {1'b0, quo_ff};
      sts.done = done_ff;
      sts.busy = busy_ff;
      if (quo_ff > lim) begin
         sts.clip = 1'b1;
         sts.quotient = neg_ff ? {1'b1, {(DataWidth-1){1'b0}}}
                               : {1'b0, {(DataWidth-1){1'b1}}};
      end else begin
         sts.clip = 1'b0;
         sts.quotient = signed_q[DataWidth-1:0];
      end
   end
endmodule

@@ rtl/sparse_triangular_solve.sv @@
// Sparse triangular solve, Q-format fixed point, CSR entries in solve order.
// An off-diagonal entry takes a store read, then a multiply-accumulate; a row end
// adds the numerator, a 64-step restoring divide (none on a zero diagonal) and
// the store write. Entries are accepted only when idle with no response pending.
// Reset (synchronous, active high) clears row state, control and config;
// the solution store is not cleared and holds garbage until written.
module sparse_triangular_solve
   import sts_pkg::*;
#(
   parameter int MAX_ROWS      = DefaultMaxRows,
   parameter int FRACTION_BITS = DefaultFracBits
) (
   input logic   clock,
   input logic   reset,
   sts_if.sink   req,
   sts_if.source rsp,
   input logic   csr_we,
   input logic   csr_wdata
);
   localparam int AddrWidth = $clog2(MAX_ROWS);
   localparam logic signed [AccWidth-1:0] SatMax = {1'b0, {(AccWidth-1){1'b1}}};
   localparam logic signed [AccWidth-1:0] SatMin = -SatMax;

   // sequencer states
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StMac  = 3'd1;
   localparam logic [2:0] StNum  = 3'd2;
   localparam logic [2:0] StDiv  = 3'd3;
   localparam logic [2:0] StOut  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       diag_first_ff;
   logic signed [AccWidth-1:0]  acc_ff, acc_in;
   logic signed [DataWidth-1:0] hdiag_ff, hdiag_in;
   logic       sat_ff, sat_in;
   req_type    cur_ff, cur_in;
   logic       col_ok_ff, col_ok_in;
   rsp_type    out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   div_cmd_type div_cmd;
   div_sts_type div_sts;
   logic signed [DataWidth-1:0] div_den_ff, div_den_in;

   logic                  ram_we;
   logic [AddrWidth-1:0]  ram_waddr, ram_raddr;
   logic [DataWidth-1:0]  ram_wdata, ram_rdata;

   req_type in_item;
   logic    accept;
   logic    is_diag;
   logic signed [AccWidth-1:0] acc_base, prod, xval;
   logic signed [AccWidth:0]   sum_wide;
   logic signed [AccWidth-1:0] rhs_scaled;

   assign in_item = req.payload;
   assign req.ready = (state_ff == StIdle) && !out_valid_ff;
   assign accept = req.valid && req.ready;
   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;

   sts_ram #(.Width(DataWidth), .Depth(MAX_ROWS)) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   sts_div u_div (.clock(clock), .reset(reset), .cmd(div_cmd), .sts(div_sts));

   // column read address is taken straight from the transaction
   assign ram_raddr = AddrWidth'(in_item.column);

   always_comb begin
      state_in = state_ff; acc_in = acc_ff; hdiag_in = hdiag_ff; sat_in = sat_ff;
      cur_in = cur_ff; col_ok_in = col_ok_ff; out_in = out_ff;
      out_valid_in = out_valid_ff; div_den_in = div_den_ff;
      div_cmd = '0; ram_we = 1'b0;
      ram_waddr = AddrWidth'(cur_ff.row); ram_wdata = div_sts.quotient;
      is_diag = diag_first_ff ? cur_ff.row_first : cur_ff.row_last;
      acc_base = cur_ff.row_first ? '0 : acc_ff;
      xval = col_ok_ff ? AccWidth'(signed'(ram_rdata)) : '0;
      prod = AccWidth'(cur_ff.entry_value) * xval;
      sum_wide = '0;
      rhs_scaled = AccWidth'(cur_ff.rhs) <<< FRACTION_BITS;
      if (rsp.valid && rsp.ready) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               cur_in = in_item;
               col_ok_in = (32'(in_item.column) < MAX_ROWS);
               state_in = StMac;
            end
         end
         StMac: begin
            // clear row state on a row start, then take diagonal or accumulate; a row end latches the divisor
            acc_in = acc_base;
            if (cur_ff.row_first) begin
               hdiag_in = '0; sat_in = 1'b0;
            end
            if (is_diag) begin
               if (diag_first_ff) hdiag_in = cur_ff.entry_value;
            end else begin
               sum_wide = {acc_base[AccWidth-1], acc_base} + {prod[AccWidth-1], prod};
               if (sum_wide > (AccWidth+1)'(SatMax)) begin
                  acc_in = SatMax; sat_in = 1'b1;
               end else if (sum_wide < (AccWidth+1)'(SatMin)) begin
                  acc_in = SatMin; sat_in = 1'b1;
               end else begin
                  acc_in = sum_wide[AccWidth-1:0];
               end
            end
            if (cur_ff.row_last) begin
               div_den_in = diag_first_ff ? (cur_ff.row_first ? cur_ff.entry_value
                                             : hdiag_ff) : cur_ff.entry_value;
               state_in = StNum;
            end else begin
               state_in = StIdle;
            end
         end
         StNum: begin
            sum_wide = {rhs_scaled[AccWidth-1], rhs_scaled} - {acc_ff[AccWidth-1], acc_ff};
            div_cmd.numerator = sum_wide[AccWidth-1:0];
            if (sum_wide > (AccWidth+1)'(SatMax)) begin
               div_cmd.numerator = SatMax; sat_in = 1'b1;
            end else if (sum_wide < (AccWidth+1)'(SatMin)) begin
               div_cmd.numerator = SatMin; sat_in = 1'b1;
            end
            div_cmd.divisor = div_den_ff;
            if (div_den_ff == '0) begin
               // zero diagonal: result 0, stored too
               ram_we = (32'(cur_ff.row) < MAX_ROWS);
               ram_wdata = '0;
               state_in = StOut;
            end else begin
               div_cmd.start = 1'b1;
               state_in = StDiv;
            end
         end
         StDiv: begin
            if (div_sts.done) begin
               ram_we = (32'(cur_ff.row) < MAX_ROWS);
               if (div_sts.clip) sat_in = 1'b1;
               state_in = StOut;
            end
         end
         StOut: begin
            out_in.solution_index = cur_ff.row;
            out_in.zero_diagonal = (div_den_ff == '0);
            out_in.solution_value = (div_den_ff == '0) ? '0 : div_sts.quotient;
            out_in.saturated = sat_ff;
            out_valid_in = 1'b1;
            acc_in = '0; hdiag_in = '0; sat_in = 1'b0;
            state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle; acc_ff <= '0; hdiag_ff <= '0; sat_ff <= 1'b0;
         out_valid_ff <= 1'b0; diag_first_ff <= 1'b0;
      end else begin
         state_ff <= state_in; acc_ff <= acc_in; hdiag_ff <= hdiag_in;
         sat_ff <= sat_in; out_valid_ff <= out_valid_in;
         if (csr_we) diag_first_ff <= csr_wdata;
      end
      cur_ff <= cur_in; col_ok_ff <= col_ok_in; out_ff <= out_in;
      div_den_ff <= div_den_in;
   end
endmodule
